// ===== design/tga_rle_pkg.sv =====
// Shared types and constants for the TGA run-length pixel decoder.
// Used by the front end, the pixel queue, the back end and the top level.
`timescale 1ns / 1ps
`default_nettype none

package tga_rle_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_RLE_MODE   = 2'd0;
  localparam logic [1:0] CFG_BPP        = 2'd1;
  localparam logic [1:0] CFG_PIX_TOTAL  = 2'd2;
  localparam logic [1:0] CFG_SKIP_BYTES = 2'd3;

  localparam int CFG_DATA_W = 25;

  // Pixel size limits in bytes
  localparam logic [2:0] BPP_MIN = 3'd2;
  localparam logic [2:0] BPP_MAX = 3'd4;

  // Input item: one byte of the file body
  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } tga_rle_in_t;

  // Result item: one decoded pixel or run
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] repeat_count;
    logic       image_done;
    logic       run_clipped;
  } tga_rle_out_t;

  // Gathered pixel as it travels from front end to back end
  typedef struct packed {
    logic [3:0][7:0] pix_bytes;
    logic [2:0]      bpp;
    logic [7:0]      count;
    logic            done;
    logic            clipped;
  } tga_rle_pix_t;

endpackage

`default_nettype wire

// ===== design/tga_rle_front.sv =====
// Front end: accepts body bytes, drops the skip area, parses packet headers,
// gathers pixel bytes and counts pixels. Depends on tga_rle_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tga_rle_front #(
  parameter int MAX_PIXELS = 16777216
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  input  tga_rle_pkg::tga_rle_in_t in_data,
  input  wire                      q_full,
  input  wire                      cfg_rle_mode,
  input  wire  [2:0]               cfg_bpp,
  input  wire  [24:0]              cfg_pix_total,
  input  wire  [16:0]              cfg_skip_bytes,
  output logic                     push,
  output tga_rle_pkg::tga_rle_pix_t push_data
);
  import tga_rle_pkg::*;

  localparam int PW = $clog2(MAX_PIXELS + 1);
  localparam int MW = (PW > 25) ? PW : 25;
  localparam int DW = (PW > 9) ? PW : 9;

  logic [16:0]     skip_left_r, skip_left_nxt;
  logic [1:0]      phase_r, phase_nxt;
  logic [3:0][7:0] bytes_r, bytes_nxt;
  logic [7:0]      pkt_left_r, pkt_left_nxt;
  logic            pkt_rep_r, pkt_rep_nxt;
  logic [PW-1:0]   pix_left_r, pix_left_nxt;

  logic [MW-1:0]   total_ext;
  logic [PW-1:0]   total_clamped;
  logic [2:0]      eff_bpp;
  logic            accept;

  assign accept = in_valid && !q_full;

  // Pixel total clamped to the supported maximum
  always_comb begin
    total_ext = MW'(cfg_pix_total);
    if (total_ext > MW'(MAX_PIXELS)) begin
      total_clamped = PW'(MAX_PIXELS);
    end else begin
      total_clamped = PW'(total_ext);
    end
  end

  // Out-of-range pixel sizes fold to the nearest legal one
  always_comb begin
    if (cfg_bpp < BPP_MIN) begin
      eff_bpp = BPP_MIN;
    end else if (cfg_bpp > BPP_MAX) begin
      eff_bpp = BPP_MAX;
    end else begin
      eff_bpp = cfg_bpp;
    end
  end

  // Per-byte decode
  always_comb begin
    logic [16:0]     skip_c;
    logic [1:0]      phase_c;
    logic [3:0][7:0] bytes_c;
    logic [7:0]      pkt_c;
    logic            rep_c;
    logic [PW-1:0]   pix_c;
    logic [DW-1:0]   cnt;
    logic [7:0]      pkt_dec;
    logic            clip;

    // frame start reloads everything before the byte is handled
    if (in_data.frame_start) begin
      skip_c  = cfg_skip_bytes;
      phase_c = '0;
      bytes_c = '0;
      pkt_c   = '0;
      rep_c   = 1'b0;
      pix_c   = total_clamped;
    end else begin
      skip_c  = skip_left_r;
      phase_c = phase_r;
      bytes_c = bytes_r;
      pkt_c   = pkt_left_r;
      rep_c   = pkt_rep_r;
      pix_c   = pix_left_r;
    end

    cnt     = DW'(1);
    pkt_dec = pkt_c - 8'd1;
    clip    = 1'b0;

    skip_left_nxt = skip_left_r;
    phase_nxt     = phase_r;
    bytes_nxt     = bytes_r;
    pkt_left_nxt  = pkt_left_r;
    pkt_rep_nxt   = pkt_rep_r;
    pix_left_nxt  = pix_left_r;
    push          = 1'b0;

    if (accept) begin
      skip_left_nxt = skip_c;
      phase_nxt     = phase_c;
      bytes_nxt     = bytes_c;
      pkt_left_nxt  = pkt_c;
      pkt_rep_nxt   = rep_c;
      pix_left_nxt  = pix_c;

      if (skip_c != '0) begin
        skip_left_nxt = skip_c - 17'd1;
      end else if (pix_c == '0) begin
        // image complete: byte ignored
      end else if (cfg_rle_mode && pkt_c == '0) begin
        // packet header
        pkt_left_nxt = {1'b0, in_data.data_byte[6:0]} + 8'd1;
        pkt_rep_nxt  = in_data.data_byte[7];
        phase_nxt    = '0;
      end else begin
        bytes_nxt[phase_c] = in_data.data_byte;
        if ({1'b0, phase_c} + 3'd1 < eff_bpp) begin
          phase_nxt = phase_c + 2'd1;
        end else begin
          phase_nxt = '0;
          push      = 1'b1;
          if (cfg_rle_mode && rep_c) begin
            // repeated run, cut at the end of the image
            if (DW'(pkt_c) > DW'(pix_c)) begin
              cnt  = DW'(pix_c);
              clip = 1'b1;
            end else begin
              cnt = DW'(pkt_c);
            end
            pkt_left_nxt = '0;
          end else if (cfg_rle_mode) begin
            // raw packet: drop the rest if the image ends here
            if (pkt_dec != '0 && pix_c == PW'(1)) begin
              clip         = 1'b1;
              pkt_left_nxt = '0;
            end else begin
              pkt_left_nxt = pkt_dec;
            end
          end
          pix_left_nxt = PW'(DW'(pix_c) - cnt);
        end
      end
    end

    push_data.pix_bytes = bytes_nxt;
    push_data.bpp       = eff_bpp;
    push_data.count     = 8'(cnt);
    push_data.done      = (pix_left_nxt == '0);
    push_data.clipped   = clip;
  end

  // State registers; reset loads the frame with register reset values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_left_r <= '0;
      phase_r     <= '0;
      bytes_r     <= '0;
      pkt_left_r  <= '0;
      pkt_rep_r   <= 1'b0;
      pix_left_r  <= PW'(1);
    end else begin
      skip_left_r <= skip_left_nxt;
      phase_r     <= phase_nxt;
      bytes_r     <= bytes_nxt;
      pkt_left_r  <= pkt_left_nxt;
      pkt_rep_r   <= pkt_rep_nxt;
      pix_left_r  <= pix_left_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/tga_rle_queue.sv =====
// Two-entry queue of gathered pixels between front end and back end.
// Depends on tga_rle_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tga_rle_queue (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       push,
  input  tga_rle_pkg::tga_rle_pix_t push_data,
  input  wire                       pop,
  output logic                      full,
  output logic                      not_empty,
  output tga_rle_pkg::tga_rle_pix_t pop_data
);
  import tga_rle_pkg::*;

  tga_rle_pix_t entry_r [2];
  logic         wr_ptr_r, wr_ptr_nxt;
  logic         rd_ptr_r, rd_ptr_nxt;
  logic [1:0]   count_r, count_nxt;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign pop_data  = entry_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== design/tga_rle_back.sv =====
// Back end: converts a gathered BGR(A) pixel to RGBA and holds the result
// in the output register. Depends on tga_rle_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tga_rle_back (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       q_not_empty,
  input  tga_rle_pkg::tga_rle_pix_t q_data,
  output logic                      pop,
  output logic                      out_valid,
  input  wire                       out_stall,
  output tga_rle_pkg::tga_rle_out_t out_data
);
  import tga_rle_pkg::*;

  logic         out_valid_r, out_valid_nxt;
  tga_rle_out_t out_data_r, out_data_nxt;

  assign pop       = q_not_empty && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Pixel format conversion
  always_comb begin
    logic [7:0] b0;
    logic [7:0] b1;
    b0 = q_data.pix_bytes[0];
    b1 = q_data.pix_bytes[1];
    if (q_data.bpp == 3'd2) begin
      // 1-5-5-5 word, channels widened by three bits
      out_data_nxt.red   = (b1 & 8'h7c) << 1;
      out_data_nxt.green = ((b1 & 8'h03) << 6) | ((b0 & 8'he0) >> 2);
      out_data_nxt.blue  = (b0 & 8'h1f) << 3;
      out_data_nxt.alpha = b1 & 8'h80;
    end else begin
      out_data_nxt.red   = q_data.pix_bytes[2];
      out_data_nxt.green = b1;
      out_data_nxt.blue  = b0;
      out_data_nxt.alpha = (q_data.bpp == 3'd4) ? q_data.pix_bytes[3] : 8'h00;
    end
    out_data_nxt.repeat_count = q_data.count;
    out_data_nxt.image_done   = q_data.done;
    out_data_nxt.run_clipped  = q_data.clipped;
  end

  // Output register valid tracking
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/tga_rle_pixel_decoder_unit.sv =====
// Top level of the TGA run-length pixel decoder: configuration registers,
// front end, pixel queue and back end. Depends on tga_rle_pkg and submodules.
`timescale 1ns / 1ps
`default_nettype none

// Decodes the pixel body of a TGA image (type 2 raw or type 10 run-length),
// one byte per cycle. The byte after the header comes with frame_start set;
// skip_bytes leading bytes are then dropped and each 2, 3 or 4 byte pixel
// yields one RGBA result, a repeated run yields a single result carrying its
// repeat count. The front end takes a byte every cycle as long as the
// two-entry pixel queue has room; the back end converts one queued pixel per
// cycle into the output register while out_stall is low, and then a full
// byte stream sees no stall. A result is held in a queue entry and then in
// the output register. Registers may be written only while no byte is in
// flight; pixel_total and skip_bytes take effect at the next frame start.
module tga_rle_pixel_decoder_unit #(
  parameter int MAX_PIXELS = 16777216
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_valid,
  output logic                      in_stall,
  input  tga_rle_pkg::tga_rle_in_t  in_data,
  output logic                      out_valid,
  input  wire                       out_stall,
  output tga_rle_pkg::tga_rle_out_t out_data,
  input  wire                       cfg_valid,
  output logic                      cfg_ready,
  input  wire  [1:0]                cfg_index,
  input  wire  [tga_rle_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tga_rle_pkg::*;

  logic         rle_mode_r;
  logic [2:0]   bpp_r;
  logic [24:0]  pix_total_r;
  logic [16:0]  skip_bytes_r;

  logic         q_full;
  logic         q_not_empty;
  logic         push;
  logic         pop;
  tga_rle_pix_t push_data;
  tga_rle_pix_t pop_data;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rle_mode_r   <= 1'b0;
      bpp_r        <= 3'd3;
      pix_total_r  <= 25'd1;
      skip_bytes_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_RLE_MODE:   rle_mode_r   <= cfg_data[0];
        CFG_BPP:        bpp_r        <= cfg_data[2:0];
        CFG_PIX_TOTAL:  pix_total_r  <= cfg_data[24:0];
        CFG_SKIP_BYTES: skip_bytes_r <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  tga_rle_front #(
    .MAX_PIXELS(MAX_PIXELS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_data        (in_data),
    .q_full         (q_full),
    .cfg_rle_mode   (rle_mode_r),
    .cfg_bpp        (bpp_r),
    .cfg_pix_total  (pix_total_r),
    .cfg_skip_bytes (skip_bytes_r),
    .push           (push),
    .push_data      (push_data)
  );

  tga_rle_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .pop_data  (pop_data)
  );

  tga_rle_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_data      (pop_data),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

`default_nettype wire
